### hdl/ampwm_pkg.sv
`timescale 1ns / 1ps

package ampwm_pkg;

  // Number of PWM channels held in the channel memory.
  localparam int CHANNELS = 8;

  // Derived widths for channel indexes and channel counts.
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(CHANNELS + 1);

  // Fixed field widths.
  localparam int TC_W       = 32;
  localparam int DUTY_W     = 16;
  localparam int PER_W      = 16;
  localparam int ALIGN_W    = 2;
  localparam int NCH_W      = 4;
  localparam int CHAN_W     = 3;
  localparam int LEVELS_W   = 8;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(TC_W + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [PER_W-1:0]   PERIOD_RST   = 16'd256;
  localparam logic [ALIGN_W-1:0] ALIGN_RST    = 2'd0;
  localparam logic [NCH_W-1:0]   CHANNELS_RST = 4'd8;

  // Alignment modes; the unused code behaves as left aligned.
  localparam logic [ALIGN_W-1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [ALIGN_W-1:0] ALIGN_RIGHT  = 2'd1;
  localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 2'd2;

  // Commands carried by an input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_DUTY = 2'd1,
    CMD_START    = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_e;

  // Channel engine sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_DIV,
    ST_RD_DUTY,
    ST_SCH_A,
    ST_SCH_B,
    ST_SCH_C,
    ST_SCH_D,
    ST_DONE
  } eng_state_e;

  // Effective configuration seen by the engine.
  typedef struct packed {
    logic [PER_W-1:0]    period;
    logic [ALIGN_W-1:0]  align;
    logic [CH_CNT_W-1:0] nchan;
  } cfg_t;

  // Result handed from the engine to the output register.
  typedef struct packed {
    logic                valid;
    logic [LEVELS_W-1:0] levels;
    logic                running;
  } res_t;

  // One entry of the channel memory.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [TC_W-1:0]   on_time;
    logic [TC_W-1:0]   off_time;
  } chan_ent_t;

  localparam int ENT_W = $bits(chan_ent_t);

endpackage

### hdl/multichannel_aligned_pwm_core.sv
`timescale 1ns / 1ps
// Multichannel PWM core, edge or center aligned, driven by command beats.
// Input channel (in_valid_i/in_ready_o) carries command, channel and duty;
// each accepted beat yields exactly one output beat with the pin levels of
// channels 0 to 7 and the running flag, after the command has been applied.
// Configuration (period, alignment, channels in use) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while no beat
// is in flight, which the block does not enforce. Per-channel duty, on time
// and off time live in one channel memory that is visited one entry at a
// time with read-modify-write: tick reads and rewrites each channel in use;
// set duty waits on the 32-step bit-serial remainder unit, then schedules;
// start reads and schedules each channel in use; stop goes to the result.
// One beat is worked at a time; the next is taken once the result has moved
// into the output register, even while that register waits on out_ready_i.
// A stalled receiver holds the output beat; when the output register and the
// engine both hold results, input is held off.
// Reset clears all channels to zero duty and low levels, zeroes the counter,
// sets the block running and loads period 256, left aligned, eight channels.
module multichannel_aligned_pwm_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  channel_i,
  input  logic [15:0] duty_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  levels_o,
  output logic        running_o
);
  import ampwm_pkg::*;

  logic [PER_W-1:0]   period_q;
  logic [ALIGN_W-1:0] align_q;
  logic [NCH_W-1:0]   nchan_q;

  cfg_t cfg;
  res_t res;
  logic res_ready;

  logic                out_valid_q;
  logic [LEVELS_W-1:0] levels_q;
  logic                running_q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      align_q  <= ALIGN_RST;
      nchan_q  <= CHANNELS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD:   period_q <= cfg_data_i[PER_W-1:0];
        REG_ALIGN:    align_q  <= cfg_data_i[ALIGN_W-1:0];
        REG_CHANNELS: nchan_q  <= cfg_data_i[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective configuration: zero period acts as one, channel count clamps.
  always_comb begin
    cfg.period = (period_q == '0) ? PER_W'(1) : period_q;
    cfg.align  = align_q;
    cfg.nchan  = (32'(nchan_q) > CHANNELS) ? CH_CNT_W'(CHANNELS) : CH_CNT_W'(nchan_q);
  end

  ampwm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (in_valid_i),
    .cmd_ready_o (in_ready_o),
    .cmd_i       (cmd_e'(command_i)),
    .chan_i      (channel_i),
    .duty_i      (duty_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register parts the engine from the receiver.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      levels_q  <= res.levels;
      running_q <= res.running;
    end
  end

  assign out_valid_o = out_valid_q;
  assign levels_o    = levels_q;
  assign running_o   = running_q;

endmodule

### hdl/ampwm_divider.sv
`timescale 1ns / 1ps

module ampwm_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ampwm_pkg::TC_W-1:0]  dividend_i,
  input  logic [ampwm_pkg::PER_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ampwm_pkg::PER_W-1:0] rem_o
);
  import ampwm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TC_W-1:0]      dvd_q;
  logic [PER_W-1:0]     rem_q;

  logic [PER_W:0]   trial;
  logic [PER_W:0]   trial_sub;
  logic             fits;
  logic [PER_W-1:0] rem_nx;

  // One restoring remainder step per cycle, dividend bits taken MSB first.
  always_comb begin
    trial     = {rem_q, dvd_q[TC_W-1]};
    trial_sub = trial - {1'b0, divisor_i};
    fits      = trial >= {1'b0, divisor_i};
    rem_nx    = fits ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(TC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and shifting dividend.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TC_W-2:0], 1'b0};
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/ampwm_engine.sv
`timescale 1ns / 1ps

module ampwm_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ampwm_pkg::cfg_t              cfg_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  ampwm_pkg::cmd_e              cmd_i,
  input  logic [ampwm_pkg::CHAN_W-1:0] chan_i,
  input  logic [ampwm_pkg::DUTY_W-1:0] duty_i,
  output ampwm_pkg::res_t              res_o,
  input  logic                         res_ready_i
);
  import ampwm_pkg::*;

  eng_state_e state_q, state_d;

  logic [CH_IDX_W-1:0] idx_q;
  logic                run_q;
  logic [TC_W-1:0]     tc_q;
  logic [CHANNELS-1:0] pin_q;
  logic [CHANNELS-1:0] vld_q;
  logic                is_start_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [TC_W-1:0]     phase_q;
  logic [PER_W-1:0]    diff_q;
  logic [DUTY_W-1:0]   dsat_q;
  logic [TC_W-1:0]     on_q;
  logic [TC_W-1:0]     off_q;

  // Channel memory with registered read data.
  chan_ent_t mem_q [CHANNELS];
  chan_ent_t rd_q;
  logic      rd_vld_q;

  logic      acc;
  logic      chan_ok;
  logic      nchan_zero;
  logic      last;
  logic [CH_CNT_W-1:0] idx_inc;
  logic [TC_W-1:0] per32;
  chan_ent_t rd_ent;
  chan_ent_t tick_ent;
  chan_ent_t wr_ent;
  logic      fire_on;
  logic      fire_off;
  logic      mem_rd;
  logic      mem_we;
  logic      div_start;
  logic      div_done;
  logic [PER_W-1:0] div_rem;
  logic [DUTY_W-1:0] duty_src;
  logic [PER_W:0]    sub_w;
  logic [PER_W-1:0]  offset;
  logic [TC_W-1:0]   off_fin;
  logic [LEVELS_W-1:0] levels;

  // Remainder unit for the start of the current period, used only by set duty.
  ampwm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tc_q),
    .divisor_i  (cfg_i.period),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Common decode.
  always_comb begin
    acc        = cmd_valid_i && (state_q == ST_IDLE);
    chan_ok    = 32'(chan_i) < 32'(cfg_i.nchan);
    nchan_zero = cfg_i.nchan == '0;
    idx_inc    = CH_CNT_W'(idx_q) + CH_CNT_W'(1);
    last       = idx_inc == cfg_i.nchan;
    per32      = TC_W'(cfg_i.period);
    rd_ent     = rd_vld_q ? rd_q : '0;
  end

  // Tick update of one channel: set on its on time, else clear on its off time.
  always_comb begin
    fire_on  = (rd_ent.duty != '0) && (rd_ent.on_time == tc_q);
    fire_off = !fire_on && (rd_ent.duty < cfg_i.period) && (rd_ent.off_time == tc_q);
    tick_ent = rd_ent;
    if (fire_on) begin
      tick_ent.on_time = rd_ent.on_time + per32;
    end
    if (fire_off) begin
      tick_ent.off_time = rd_ent.off_time + per32;
    end
  end

  // Scheduling arithmetic: saturating period minus duty, alignment offset and off time wrap.
  always_comb begin
    duty_src = is_start_q ? rd_ent.duty : duty_q;
    sub_w    = {1'b0, cfg_i.period} - {1'b0, duty_src};
    case (cfg_i.align)
      ALIGN_RIGHT:  offset = diff_q;
      ALIGN_CENTER: offset = diff_q >> 1;
      default:      offset = '0;
    endcase
    off_fin = (tc_q >= off_q) ? off_q + per32 : off_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd_i)
            CMD_TICK:     state_d = (run_q && !nchan_zero) ? ST_TICK_RD : ST_DONE;
            CMD_SET_DUTY: state_d = chan_ok ? ST_DIV : ST_DONE;
            CMD_START:    state_d = nchan_zero ? ST_DONE : ST_RD_DUTY;
            CMD_STOP:     state_d = ST_DONE;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK_RD: state_d = ST_TICK_WR;
      ST_TICK_WR: state_d = last ? ST_DONE : ST_TICK_RD;
      ST_DIV:     state_d = div_done ? ST_SCH_A : ST_DIV;
      ST_RD_DUTY: state_d = ST_SCH_A;
      ST_SCH_A:   state_d = ST_SCH_B;
      ST_SCH_B:   state_d = ST_SCH_C;
      ST_SCH_C:   state_d = ST_SCH_D;
      ST_SCH_D:   state_d = (is_start_q && !last) ? ST_RD_DUTY : ST_DONE;
      ST_DONE:    state_d = res_ready_i ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port, divider start, handshakes.
  always_comb begin
    mem_rd    = (state_q == ST_TICK_RD) || (state_q == ST_RD_DUTY);
    mem_we    = (state_q == ST_TICK_WR) || (state_q == ST_SCH_D);
    wr_ent    = tick_ent;
    if (state_q == ST_SCH_D) begin
      wr_ent.duty     = dsat_q;
      wr_ent.on_time  = on_q;
      wr_ent.off_time = off_fin;
    end
    div_start   = acc && (cmd_i == CMD_SET_DUTY) && chan_ok;
    cmd_ready_o = state_q == ST_IDLE;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      run_q      <= 1'b1;
      tc_q       <= '0;
      pin_q      <= '0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      is_start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        is_start_q <= cmd_i == CMD_START;
        idx_q      <= (cmd_i == CMD_SET_DUTY) ? CH_IDX_W'(chan_i) : '0;
        unique case (cmd_i)
          CMD_TICK: begin
            if (run_q) begin
              tc_q <= tc_q + TC_W'(1);
            end
          end
          CMD_START: begin
            run_q <= 1'b1;
            tc_q  <= '0;
          end
          CMD_STOP: run_q <= 1'b0;
          default: ;
        endcase
      end
      if (mem_rd) begin
        rd_vld_q <= vld_q[idx_q];
      end
      if (mem_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (state_q == ST_TICK_WR) begin
        if (fire_on) begin
          pin_q[idx_q] <= 1'b1;
        end else if (fire_off) begin
          pin_q[idx_q] <= 1'b0;
        end
        if (!last) begin
          idx_q <= CH_IDX_W'(idx_inc);
        end
      end
      if ((state_q == ST_SCH_D) && is_start_q && !last) begin
        idx_q <= CH_IDX_W'(idx_inc);
      end
    end
  end

  // Scheduling datapath registers.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      duty_q  <= duty_i;
      phase_q <= '0;
    end
    if ((state_q == ST_DIV) && div_done) begin
      phase_q <= tc_q - TC_W'(div_rem);
    end
    if (state_q == ST_SCH_A) begin
      dsat_q <= sub_w[PER_W] ? cfg_i.period : duty_src;
      diff_q <= sub_w[PER_W] ? '0 : sub_w[PER_W-1:0];
    end
    if (state_q == ST_SCH_B) begin
      on_q <= phase_q + TC_W'(offset);
    end
    if (state_q == ST_SCH_C) begin
      off_q <= on_q + TC_W'(dsat_q);
      on_q  <= (tc_q >= on_q) ? on_q + per32 : on_q;
    end
  end

  // Channel memory: one read or one write per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= wr_ent;
    end
    if (mem_rd) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Pin levels on the result; only the first eight channels are visible.
  for (genvar g = 0; g < LEVELS_W; g++) begin : g_lvl
    if (g < CHANNELS) begin : g_on
      assign levels[g] = pin_q[g];
    end else begin : g_off
      assign levels[g] = 1'b0;
    end
  end

  always_comb begin
    res_o.valid   = state_q == ST_DONE;
    res_o.levels  = levels;
    res_o.running = run_q;
  end

endmodule
